// ===== rtl/core/stt_pkg.sv =====
// Shared types and constants for the software timer table.
`default_nettype none

package stt_pkg;

  // Function codes carried by a request.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_MODIFY = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Slot modes.
  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_STOP     = 2'd1;
  localparam logic [1:0] MODE_ONCE     = 2'd2;
  localparam logic [1:0] MODE_PERIODIC = 2'd3;

  // Response kinds.
  localparam logic [2:0] KIND_FIRE      = 3'd0;
  localparam logic [2:0] KIND_TICK_DONE = 3'd1;
  localparam logic [2:0] KIND_ADD       = 3'd2;
  localparam logic [2:0] KIND_COUNT     = 3'd3;
  localparam logic [2:0] KIND_ACK       = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot_id;
    logic [1:0]  mode;
    logic [15:0] count_value;
    logic [15:0] compare_value;
    logic        notify;
  } stt_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  result_slot;
    logic [15:0] result_count;
    logic        ok;
    logic        last;
  } stt_rsp_t;

  // Source selection for the output register.
  typedef enum logic [2:0] {
    OUT_PEND_MID  = 3'd0,
    OUT_PEND_LAST = 3'd1,
    OUT_TICK_DONE = 3'd2,
    OUT_ADD_OK    = 3'd3,
    OUT_ADD_FAIL  = 3'd4,
    OUT_EXEC      = 3'd5
  } out_src_e;

  // Controller state, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TICK  = 5'b00010,
    ST_TDONE = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EXEC  = 5'b10000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     req_load;
    logic     idx_inc;
    logic     tick_wr;
    logic     add_wr;
    logic     exec_wr;
    logic     pend_load;
    logic     pend_clr;
    logic     out_load;
    out_src_e out_src;
  } stt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] new_func;
    logic       new_mode_nz;
    logic       slot_run;
    logic       slot_expire;
    logic       slot_notify;
    logic       slot_free;
    logic       idx_last;
    logic       pend_valid;
    logic       out_free;
  } stt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/software_timer_table.sv =====
// Top level of the software timer table: controller plus slot datapath.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------
//   in      | input     | in_valid_i/in_ready_o   | in_req_i  (stt_req_t)
//   out     | output    | out_valid_o/out_ready_i | out_rsp_o (stt_rsp_t)
//
// One request is processed at a time. A tick walks the slots one per cycle while
// the output can take its fires; an add searches slots one per cycle until it
// finds a free slot or the last one; delete, modify and read are handled in the
// execute state. The single slot read port of the datapath sets this pace. Reset
// clears every slot to free. A stalled output holds back the scan only when a
// further response has to be written while the output register is still full.
`default_nettype none

module software_timer_table #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire stt_pkg::stt_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output stt_pkg::stt_rsp_t      out_rsp_o
);
  import stt_pkg::*;

  stt_cmd_t  cmd;
  stt_stat_t stat;

  stt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/stt_datapath.sv =====
// Slot storage, scan index, pending fire buffer and output register.
`default_nettype none

module stt_datapath #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stt_pkg::stt_req_t in_req_i,
  input  wire stt_pkg::stt_cmd_t cmd_i,
  output stt_pkg::stt_stat_t     stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output stt_pkg::stt_rsp_t      out_rsp_o
);
  import stt_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  stt_req_t        req_q;
  logic            req_ok_q;
  logic [IdxW-1:0] idx_q;
  logic            pend_valid_q;
  logic [IdxW-1:0] pend_slot_q;
  logic            out_valid_q;
  stt_rsp_t        out_q;
  stt_rsp_t        rsp_d;

  logic [1:0]  mode_q   [SLOT_COUNT];
  logic [15:0] count_q  [SLOT_COUNT];
  logic [15:0] cmp_q    [SLOT_COUNT];
  logic        notify_q [SLOT_COUNT];

  logic [1:0]  rd_mode;
  logic [15:0] rd_count;
  logic [15:0] rd_cmp;
  logic        rd_notify;
  logic        rd_run;
  logic        rd_expire;

  logic        wr_en;
  logic [1:0]  nx_mode;
  logic [15:0] nx_count;
  logic [15:0] nx_cmp;
  logic        nx_notify;

  // Read the slot selected by the index register.
  assign rd_mode   = mode_q[idx_q];
  assign rd_count  = count_q[idx_q];
  assign rd_cmp    = cmp_q[idx_q];
  assign rd_notify = notify_q[idx_q];
  assign rd_run    = (rd_mode == MODE_ONCE) || (rd_mode == MODE_PERIODIC);
  assign rd_expire = (rd_count >= rd_cmp);

  // Request register, id check and slot index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q    <= in_req_i;
      req_ok_q <= ({1'b0, in_req_i.slot_id} < 5'(SLOT_COUNT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.req_load) begin
      if ((in_req_i.func == FUNC_TICK) || (in_req_i.func == FUNC_ADD)) begin
        idx_q <= '0;
      end else begin
        idx_q <= in_req_i.slot_id[IdxW-1:0];
      end
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Next contents of the selected slot.
  always_comb begin
    wr_en     = 1'b0;
    nx_mode   = rd_mode;
    nx_count  = rd_count;
    nx_cmp    = rd_cmp;
    nx_notify = rd_notify;
    if (cmd_i.tick_wr && rd_run) begin
      wr_en = 1'b1;
      if (rd_expire) begin
        nx_count = 16'd1;
        if (rd_mode == MODE_ONCE) begin
          nx_mode = MODE_STOP;
        end
      end else begin
        nx_count = rd_count + 16'd1;
      end
    end
    if (cmd_i.add_wr) begin
      wr_en     = 1'b1;
      nx_mode   = req_q.mode;
      nx_count  = 16'd1;
      nx_cmp    = req_q.compare_value;
      nx_notify = req_q.notify;
    end
    if (cmd_i.exec_wr && req_ok_q) begin
      if (req_q.func == FUNC_DELETE) begin
        wr_en     = 1'b1;
        nx_mode   = MODE_FREE;
        nx_notify = 1'b0;
      end else if (req_q.func == FUNC_MODIFY) begin
        wr_en = 1'b1;
        if (req_q.mode != MODE_FREE) begin
          nx_mode = req_q.mode;
        end
        if (req_q.count_value != 16'd0) begin
          nx_count = req_q.count_value;
        end
        if (req_q.compare_value != 16'd0) begin
          nx_cmp = req_q.compare_value;
        end
      end
    end
  end

  // Slot storage; all slots reset to free with cleared fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode_q[i]   <= MODE_FREE;
        count_q[i]  <= '0;
        cmp_q[i]    <= '0;
        notify_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (idx_q == IdxW'(i)) begin
          mode_q[i]   <= nx_mode;
          count_q[i]  <= nx_count;
          cmp_q[i]    <= nx_cmp;
          notify_q[i] <= nx_notify;
        end
      end
    end
  end

  // One fire is held back until it is known whether it is the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
    end else if (cmd_i.pend_load) begin
      pend_valid_q <= 1'b1;
      pend_slot_q  <= idx_q;
    end else if (cmd_i.pend_clr) begin
      pend_valid_q <= 1'b0;
    end
  end

  // Response selection.
  always_comb begin
    rsp_d              = '0;
    rsp_d.kind         = KIND_ACK;
    rsp_d.last         = 1'b1;
    unique case (cmd_i.out_src)
      OUT_PEND_MID: begin
        rsp_d.kind        = KIND_FIRE;
        rsp_d.result_slot = 4'(pend_slot_q);
        rsp_d.ok          = 1'b1;
        rsp_d.last        = 1'b0;
      end
      OUT_PEND_LAST: begin
        rsp_d.kind        = KIND_FIRE;
        rsp_d.result_slot = 4'(pend_slot_q);
        rsp_d.ok          = 1'b1;
      end
      OUT_TICK_DONE: begin
        rsp_d.kind = KIND_TICK_DONE;
        rsp_d.ok   = 1'b1;
      end
      OUT_ADD_OK: begin
        rsp_d.kind        = KIND_ADD;
        rsp_d.result_slot = 4'(idx_q);
        rsp_d.ok          = 1'b1;
      end
      OUT_ADD_FAIL: begin
        rsp_d.kind = KIND_ADD;
      end
      OUT_EXEC: begin
        unique case (req_q.func)
          FUNC_DELETE, FUNC_MODIFY: begin
            rsp_d.ok = req_ok_q;
          end
          FUNC_READ: begin
            rsp_d.kind         = KIND_COUNT;
            rsp_d.result_count = req_ok_q ? rd_count : 16'd0;
            rsp_d.ok           = req_ok_q;
          end
          FUNC_ADD: begin
            rsp_d.kind = KIND_ADD;
          end
          default: begin
            rsp_d.kind = KIND_ACK;
          end
        endcase
      end
      default: begin
        rsp_d.kind = KIND_ACK;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Status toward the controller.
  assign stat_o.new_func    = in_req_i.func;
  assign stat_o.new_mode_nz = (in_req_i.mode != MODE_FREE);
  assign stat_o.slot_run    = rd_run;
  assign stat_o.slot_expire = rd_expire;
  assign stat_o.slot_notify = rd_notify;
  assign stat_o.slot_free   = (rd_mode == MODE_FREE);
  assign stat_o.idx_last    = (idx_q == IdxW'(SLOT_COUNT - 1));
  assign stat_o.pend_valid  = pend_valid_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/core/stt_ctrl.sv =====
// Controller state machine that sequences tick scans, add searches and single commands.
`default_nettype none

module stt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire stt_pkg::stt_stat_t stat_i,
  output stt_pkg::stt_cmd_t       cmd_o
);
  import stt_pkg::*;

  state_e state_q, state_d;
  logic   fire;

  assign fire       = stat_i.slot_run && stat_i.slot_expire && stat_i.slot_notify;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_src = OUT_EXEC;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          if (stat_i.new_func == FUNC_TICK) begin
            state_d = ST_TICK;
          end else if ((stat_i.new_func == FUNC_ADD) && stat_i.new_mode_nz) begin
            state_d = ST_ADD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_TICK: begin
        // A second fire can only go ahead when the held one can be sent.
        if (!(fire && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.tick_wr = 1'b1;
          if (fire) begin
            cmd_o.pend_load = 1'b1;
            if (stat_i.pend_valid) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_src  = OUT_PEND_MID;
            end
          end
          if (stat_i.idx_last) begin
            state_d = ST_TDONE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_TDONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = stat_i.pend_valid ? OUT_PEND_LAST : OUT_TICK_DONE;
          cmd_o.pend_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ADD: begin
        if (stat_i.slot_free) begin
          if (stat_i.out_free) begin
            cmd_o.add_wr   = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = OUT_ADD_OK;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.idx_last) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = OUT_ADD_FAIL;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec_wr  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_EXEC;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== dv/software_timer_table_tb.sv =====
// Testbench for the software timer table: directed and random requests checked by a scoreboard.

module software_timer_table_tb;
  import stt_pkg::*;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned IDLE_PCT = 27;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS = 300;

  // Scoreboard with its own copy of the slot table.
  class timer_scoreboard;
    logic [1:0]  slot_mode_q    [SLOT_COUNT];
    logic [15:0] slot_count_q   [SLOT_COUNT];
    logic [15:0] slot_compare_q [SLOT_COUNT];
    logic        slot_notify_q  [SLOT_COUNT];
    stt_rsp_t    expected_q [$];
    int          errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_mode_q[i]    = MODE_FREE;
        slot_count_q[i]   = '0;
        slot_compare_q[i] = '0;
        slot_notify_q[i]  = 1'b0;
      end
      errors = 0;
    endfunction

    function void push_rsp(logic [2:0] kind, logic [3:0] slot, logic [15:0] cnt,
                           logic ok, logic last);
      stt_rsp_t rsp;
      rsp.kind         = kind;
      rsp.result_slot  = slot;
      rsp.result_count = cnt;
      rsp.ok           = ok;
      rsp.last         = last;
      expected_q.push_back(rsp);
    endfunction

    // Updates the table for an accepted request and queues the responses it causes.
    function void note_request(stt_req_t req);
      int   fired [$];
      logic id_ok;
      id_ok = (req.slot_id < SLOT_COUNT);
      case (req.func)
        FUNC_TICK: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_mode_q[i] > MODE_STOP) begin
              if (slot_count_q[i] >= slot_compare_q[i]) begin
                slot_count_q[i] = 16'd1;
                if (slot_mode_q[i] == MODE_ONCE) slot_mode_q[i] = MODE_STOP;
                if (slot_notify_q[i]) fired.push_back(i);
              end else begin
                slot_count_q[i] = slot_count_q[i] + 16'd1;
              end
            end
          end
          if (fired.size() == 0) begin
            push_rsp(KIND_TICK_DONE, 4'd0, 16'd0, 1'b1, 1'b1);
          end else begin
            foreach (fired[k])
              push_rsp(KIND_FIRE, 4'(fired[k]), 16'd0, 1'b1, k == fired.size() - 1);
          end
        end
        FUNC_ADD: begin
          int slot;
          slot = -1;
          if (req.mode != MODE_FREE) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (slot < 0 && slot_mode_q[i] == MODE_FREE) slot = i;
            end
          end
          if (slot >= 0) begin
            slot_count_q[slot]   = 16'd1;
            slot_compare_q[slot] = req.compare_value;
            slot_notify_q[slot]  = req.notify;
            slot_mode_q[slot]    = req.mode;
            push_rsp(KIND_ADD, 4'(slot), 16'd0, 1'b1, 1'b1);
          end else begin
            push_rsp(KIND_ADD, 4'd0, 16'd0, 1'b0, 1'b1);
          end
        end
        FUNC_DELETE: begin
          if (id_ok) begin
            slot_mode_q[req.slot_id]   = MODE_FREE;
            slot_notify_q[req.slot_id] = 1'b0;
          end
          push_rsp(KIND_ACK, 4'd0, 16'd0, id_ok, 1'b1);
        end
        FUNC_MODIFY: begin
          if (id_ok) begin
            if (req.mode != MODE_FREE) slot_mode_q[req.slot_id] = req.mode;
            if (req.count_value != 16'd0) slot_count_q[req.slot_id] = req.count_value;
            if (req.compare_value != 16'd0) slot_compare_q[req.slot_id] = req.compare_value;
          end
          push_rsp(KIND_ACK, 4'd0, 16'd0, id_ok, 1'b1);
        end
        FUNC_READ: begin
          push_rsp(KIND_COUNT, 4'd0, id_ok ? slot_count_q[req.slot_id] : 16'd0, id_ok, 1'b1);
        end
        default: begin
          push_rsp(KIND_ACK, 4'd0, 16'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    // Compares a delivered response with the oldest queued one.
    function void check_response(stt_rsp_t rsp);
      stt_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $error("unexpected response: kind %0d slot %0d", rsp.kind, rsp.result_slot);
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (rsp.kind !== exp_rsp.kind) begin
        $error("kind: expected %0d, actual %0d", exp_rsp.kind, rsp.kind);
        errors++;
      end
      if (rsp.result_slot !== exp_rsp.result_slot) begin
        $error("result_slot: expected %0d, actual %0d", exp_rsp.result_slot, rsp.result_slot);
        errors++;
      end
      if (rsp.result_count !== exp_rsp.result_count) begin
        $error("result_count: expected %0d, actual %0d", exp_rsp.result_count,
               rsp.result_count);
        errors++;
      end
      if (rsp.ok !== exp_rsp.ok) begin
        $error("ok: expected %0d, actual %0d", exp_rsp.ok, rsp.ok);
        errors++;
      end
      if (rsp.last !== exp_rsp.last) begin
        $error("last: expected %0d, actual %0d", exp_rsp.last, rsp.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  stt_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  stt_rsp_t out_rsp_o;

  timer_scoreboard board;
  bit          no_idle    = 1'b0;
  bit          hold_start = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned quiet_cycles = 0;

  software_timer_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off when the sender asks for one.
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Response checking and the watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_response(out_rsp_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  function automatic stt_req_t make_req(logic [2:0] func, logic [3:0] id, logic [1:0] mode,
                                        logic [15:0] cnt, logic [15:0] cmp, logic nfy);
    stt_req_t req;
    req.func          = func;
    req.slot_id       = id;
    req.mode          = mode;
    req.count_value   = cnt;
    req.compare_value = cmp;
    req.notify        = nfy;
    return req;
  endfunction

  // Random request: mostly valid ids and small counters, so that slots really expire.
  function automatic stt_req_t random_req();
    stt_req_t    req;
    int unsigned pick;
    req  = stt_req_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 35)      req.func = FUNC_TICK;
    else if (pick < 52) req.func = FUNC_ADD;
    else if (pick < 62) req.func = FUNC_DELETE;
    else if (pick < 80) req.func = FUNC_MODIFY;
    else if (pick < 95) req.func = FUNC_READ;
    else                req.func = 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 85) req.slot_id = 4'($urandom_range(SLOT_COUNT - 1));
    else                         req.slot_id = 4'($urandom_range(15, SLOT_COUNT));
    if (req.func == FUNC_ADD && $urandom_range(99) < 85)
      req.mode = 2'($urandom_range(3, 1));
    pick = $urandom_range(99);
    if (pick < 40)      req.count_value = 16'd0;
    else if (pick < 80) req.count_value = 16'($urandom_range(12, 1));
    pick = $urandom_range(99);
    if (pick < 10)      req.compare_value = 16'd0;
    else if (pick < 70) req.compare_value = 16'($urandom_range(12, 1));
    return req;
  endfunction

  // Offers one request after a random gap and waits for its handshake.
  task automatic send_request(stt_req_t req);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(req);
    @(negedge clk_i);
  endtask

  // Stops offering until every queued response has been delivered.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table: a read, an invalid read and a tick with nothing running.
    send_request(make_req(FUNC_READ, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    send_request(make_req(FUNC_READ, 4'd15, MODE_PERIODIC, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_req(FUNC_TICK, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    // An add with mode zero fails; then fill the whole table, and one more add fails.
    send_request(make_req(FUNC_ADD, 4'd0, MODE_FREE, 16'd0, 16'd3, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'd0, 16'd0, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_ONCE, 16'd0, 16'd2, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_STOP, 16'd0, 16'hFFFF, 1'b0));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'd0, 16'd1, 1'b0));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_ONCE, 16'd0, 16'd0, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'd0, 16'd2, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'd0, 16'd0, 1'b1));
    send_request(make_req(FUNC_ADD, 4'd0, MODE_PERIODIC, 16'd0, 16'd5, 1'b1));
    // Several ticks: one-shot expiry and compare zero expiring every time.
    send_request(make_req(FUNC_TICK, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    send_request(make_req(FUNC_TICK, 4'd15, MODE_PERIODIC, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_req(FUNC_TICK, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    // Counter at the top value expires on the next tick.
    send_request(make_req(FUNC_MODIFY, 4'd3, MODE_FREE, 16'hFFFF, 16'd0, 1'b0));
    send_request(make_req(FUNC_TICK, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    // Invalid ids, a no-change modify, delete and modify of a free slot.
    send_request(make_req(FUNC_MODIFY, 4'd8, MODE_PERIODIC, 16'd4, 16'd4, 1'b1));
    send_request(make_req(FUNC_MODIFY, 4'd2, MODE_FREE, 16'd0, 16'd0, 1'b1));
    send_request(make_req(FUNC_DELETE, 4'd15, MODE_FREE, 16'd0, 16'd0, 1'b0));
    send_request(make_req(FUNC_DELETE, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));
    send_request(make_req(FUNC_MODIFY, 4'd0, MODE_PERIODIC, 16'd0, 16'd0, 1'b0));
    // Unknown function codes.
    send_request(make_req(3'd5, 4'd1, MODE_ONCE, 16'd1, 16'd1, 1'b1));
    send_request(make_req(3'd7, 4'd15, MODE_PERIODIC, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_req(FUNC_TICK, 4'd0, MODE_FREE, 16'd0, 16'd0, 1'b0));

    // Random part, with a long receiver hold-off, a stretch without gaps and one drain.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_start = 1'b1;
      no_idle = (n >= 150 && n < 200);
      if (n == 220) wait_for_drain();
      send_request(random_req());
    end

    wait_for_drain();
    repeat (20) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_datapath.sv
rtl/core/stt_ctrl.sv
rtl/core/software_timer_table.sv
dv/software_timer_table_tb.sv
